### src/indexed_sequence_store_core_assert.svh
// Assertion macros for the indexed sequence store.
// Included by indexed_sequence_store_core, the module that carries concurrent checks; no other dependencies.
`ifndef INDEXED_SEQUENCE_STORE_CORE_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define ISQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("isq same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define ISQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("isq next-cycle check failed");
`else
`define ISQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ISQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### src/isq_pkg.sv
// Shared types, constants and helpers of the indexed sequence store.
// Used by every module of the block but isq_ram; depends on nothing.
package isq_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int OP_BITS   = 3;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic [ADDR_BITS-1:0]        t_addr;
    typedef logic [CNT_BITS-1:0]         t_cnt;

    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_READ_AT    = 3'd3,
        OP_INSERT_AT  = 3'd4,
        OP_MAX_MIN    = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_PUT,
        S_SCAN,
        S_MMOUT
    } t_state;

    typedef struct packed {
        logic [OP_BITS-1:0] operation;
        t_cnt               position;
        t_word              value;
    } t_req;

    typedef struct packed {
        t_word   read_value;
        t_word   min_value;
        t_cnt    count;
        t_status status;
    } t_rsp;

    // Control of the shared max/min compare unit.
    typedef struct packed {
        logic load;
        logic update;
    } t_mm_ctrl;

    // Ring slot of the entry at index idx from the front.
    function automatic t_addr slot_of(t_addr head, t_cnt idx);
        logic [CNT_BITS:0] sum;
        sum = (CNT_BITS+1)'(head) + (CNT_BITS+1)'(idx);
        if (sum >= (CNT_BITS+1)'(DEPTH)) begin
            sum = sum - (CNT_BITS+1)'(DEPTH);
        end
        return sum[ADDR_BITS-1:0];
    endfunction

endpackage

### src/isq_ram.sv
// Simple dual-port word memory: one write port, one registered read port.
// Generic; no package dependency.
module isq_ram #(
    parameter int unsigned ADDR_W = 6,
    parameter int unsigned DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [(2**ADDR_W)];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/isq_minmax.sv
// Shared signed compare unit that tracks the running maximum and minimum.
// Depends on isq_pkg for the word and control types.
module isq_minmax (
    input  logic              i_clk,
    input  isq_pkg::t_mm_ctrl i_ctrl,
    input  isq_pkg::t_word    i_word,
    output isq_pkg::t_word    o_max,
    output isq_pkg::t_word    o_min
);

    isq_pkg::t_word r_max;
    isq_pkg::t_word r_min;
    isq_pkg::t_word n_max;
    isq_pkg::t_word n_min;

    always_comb begin
        n_max = r_max;
        n_min = r_min;
        if (i_ctrl.load) begin
            n_max = i_word;
            n_min = i_word;
        end else if (i_ctrl.update) begin
            if (i_word > r_max) begin
                n_max = i_word;
            end
            if (i_word < r_min) begin
                n_min = i_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_max <= n_max;
        r_min <= n_min;
    end

    assign o_max = r_max;
    assign o_min = r_min;

endmodule

### src/indexed_sequence_store_core.sv
// Top level of the indexed sequence store: request sequencer and ring datapath.
// Depends on isq_pkg, isq_ram, isq_minmax and indexed_sequence_store_core_assert.svh.
//
//  Channel   | Signals                  | Handshake
//  ----------+--------------------------+-------------------------------------
//  request   | start, i_req, busy       | word taken at edge with start & !busy
//  response  | o_strobe, o_rsp          | word shown one cycle, no back-pressure
//
// The single memory port pair paces the long requests: insert moves one entry
// and max/min compares one entry per cycle through the shared compare unit.
// Reset clears state, head, count and strobe only; entry storage is not
// cleared, as no request reads a slot outside the held range.
// busy falls in the cycle the response word is shown; push and errors never
// raise it. The receiver cannot stall.

`include "indexed_sequence_store_core_assert.svh"

module indexed_sequence_store_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  isq_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output isq_pkg::t_rsp o_rsp
);

    isq_pkg::t_state r_state;
    isq_pkg::t_state n_state;
    isq_pkg::t_addr  r_head;
    isq_pkg::t_addr  n_head;
    isq_pkg::t_cnt   r_held;
    isq_pkg::t_cnt   n_held;
    isq_pkg::t_cnt   r_idx;
    isq_pkg::t_cnt   n_idx;
    isq_pkg::t_cnt   r_pos;
    isq_pkg::t_cnt   n_pos;
    isq_pkg::t_word  r_val;
    isq_pkg::t_word  n_val;
    logic            r_strobe;
    logic            n_strobe;
    isq_pkg::t_rsp   r_rsp;
    isq_pkg::t_rsp   n_rsp;

    logic              accept;
    logic              full;
    logic              empty;
    isq_pkg::t_op      op;
    isq_pkg::t_cnt     idx_inc;
    isq_pkg::t_cnt     idx_dec;
    isq_pkg::t_addr    head_dec;

    logic              ram_we;
    isq_pkg::t_addr    ram_waddr;
    isq_pkg::t_word    ram_wdata;
    isq_pkg::t_addr    ram_raddr;
    isq_pkg::t_word    ram_rdata;

    isq_pkg::t_mm_ctrl mm_ctrl;
    isq_pkg::t_word    mm_max;
    isq_pkg::t_word    mm_min;

    assign accept   = start && (r_state == isq_pkg::S_IDLE);
    assign busy     = (r_state != isq_pkg::S_IDLE);
    assign full     = (r_held == isq_pkg::CNT_BITS'(isq_pkg::DEPTH));
    assign empty    = (r_held == '0);
    assign op       = isq_pkg::t_op'(i_req.operation);
    assign idx_inc  = r_idx + isq_pkg::CNT_BITS'(1);
    assign idx_dec  = r_idx - isq_pkg::CNT_BITS'(1);
    // Front slot moves back one place, wrapping to the top of the ring.
    assign head_dec = (r_head == '0) ? isq_pkg::ADDR_BITS'(isq_pkg::DEPTH - 1)
                                     : r_head - isq_pkg::ADDR_BITS'(1);

    isq_ram #(
        .ADDR_W (isq_pkg::ADDR_BITS),
        .DATA_W (isq_pkg::WORD_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    isq_minmax u_minmax (
        .i_clk  (i_clk),
        .i_ctrl (mm_ctrl),
        .i_word (ram_rdata),
        .o_max  (mm_max),
        .o_min  (mm_min)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            isq_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (op)
                        isq_pkg::OP_POP_FRONT: begin
                            if (!empty) begin
                                n_state = isq_pkg::S_READ;
                            end
                        end
                        isq_pkg::OP_READ_AT: begin
                            if (i_req.position < r_held) begin
                                n_state = isq_pkg::S_READ;
                            end
                        end
                        isq_pkg::OP_INSERT_AT: begin
                            if (!full && (i_req.position <= r_held)) begin
                                n_state = (i_req.position == r_held) ? isq_pkg::S_PUT
                                                                     : isq_pkg::S_SHIFT;
                            end
                        end
                        isq_pkg::OP_MAX_MIN: begin
                            if (!empty) begin
                                n_state = isq_pkg::S_SCAN;
                            end
                        end
                        default: n_state = isq_pkg::S_IDLE;
                    endcase
                end
            end
            isq_pkg::S_READ:  n_state = isq_pkg::S_IDLE;
            isq_pkg::S_SHIFT: begin
                if (r_idx == r_pos) begin
                    n_state = isq_pkg::S_PUT;
                end
            end
            isq_pkg::S_PUT:   n_state = isq_pkg::S_IDLE;
            isq_pkg::S_SCAN: begin
                if (idx_inc >= r_held) begin
                    n_state = isq_pkg::S_MMOUT;
                end
            end
            isq_pkg::S_MMOUT: n_state = isq_pkg::S_IDLE;
            default:          n_state = isq_pkg::S_IDLE;
        endcase
    end

    // Datapath controls, memory ports and the response word.
    always_comb begin
        n_head    = r_head;
        n_held    = r_held;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_val     = r_val;
        n_strobe  = 1'b0;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_waddr = r_head;
        ram_wdata = r_val;
        ram_raddr = r_head;
        mm_ctrl   = '0;

        unique case (r_state)
            isq_pkg::S_IDLE: begin
                if (accept) begin
                    n_pos            = i_req.position;
                    n_val            = i_req.value;
                    n_rsp.read_value = '0;
                    n_rsp.min_value  = '0;
                    n_rsp.count      = r_held;
                    n_rsp.status     = isq_pkg::ST_OK;
                    unique case (op)
                        isq_pkg::OP_PUSH_FRONT: begin
                            n_strobe = 1'b1;
                            if (full) begin
                                n_rsp.status = isq_pkg::ST_FULL;
                            end else begin
                                // Step the front back, then drop the word there.
                                ram_we      = 1'b1;
                                ram_waddr   = head_dec;
                                ram_wdata   = i_req.value;
                                n_head      = head_dec;
                                n_held      = r_held + isq_pkg::CNT_BITS'(1);
                                n_rsp.count = n_held;
                            end
                        end
                        isq_pkg::OP_PUSH_BACK: begin
                            n_strobe = 1'b1;
                            if (full) begin
                                n_rsp.status = isq_pkg::ST_FULL;
                            end else begin
                                ram_we      = 1'b1;
                                ram_waddr   = isq_pkg::slot_of(r_head, r_held);
                                ram_wdata   = i_req.value;
                                n_held      = r_held + isq_pkg::CNT_BITS'(1);
                                n_rsp.count = n_held;
                            end
                        end
                        isq_pkg::OP_POP_FRONT: begin
                            if (empty) begin
                                n_strobe     = 1'b1;
                                n_rsp.status = isq_pkg::ST_EMPTY;
                            end else begin
                                // Fetch the front word; count and head advance now.
                                ram_raddr   = r_head;
                                n_head      = isq_pkg::slot_of(r_head, isq_pkg::CNT_BITS'(1));
                                n_held      = r_held - isq_pkg::CNT_BITS'(1);
                                n_rsp.count = n_held;
                            end
                        end
                        isq_pkg::OP_READ_AT: begin
                            if (i_req.position >= r_held) begin
                                n_strobe     = 1'b1;
                                n_rsp.status = isq_pkg::ST_RANGE;
                            end else begin
                                ram_raddr = isq_pkg::slot_of(r_head, i_req.position);
                            end
                        end
                        isq_pkg::OP_INSERT_AT: begin
                            if (full) begin
                                n_strobe     = 1'b1;
                                n_rsp.status = isq_pkg::ST_FULL;
                            end else if (i_req.position > r_held) begin
                                n_strobe     = 1'b1;
                                n_rsp.status = isq_pkg::ST_RANGE;
                            end else if (i_req.position != r_held) begin
                                // Start the move at the back entry.
                                n_idx     = r_held - isq_pkg::CNT_BITS'(1);
                                ram_raddr = isq_pkg::slot_of(r_head, n_idx);
                            end
                        end
                        isq_pkg::OP_MAX_MIN: begin
                            if (empty) begin
                                n_strobe     = 1'b1;
                                n_rsp.status = isq_pkg::ST_EMPTY;
                            end else begin
                                n_idx     = '0;
                                ram_raddr = r_head;
                            end
                        end
                        default: begin
                            // Unused codes: answer with no change.
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            isq_pkg::S_READ: begin
                n_strobe         = 1'b1;
                n_rsp.read_value = ram_rdata;
            end
            isq_pkg::S_SHIFT: begin
                // Write the word read last cycle one place toward the back,
                // and fetch the next one in the same cycle.
                ram_we    = 1'b1;
                ram_waddr = isq_pkg::slot_of(r_head, idx_inc);
                ram_wdata = ram_rdata;
                if (r_idx != r_pos) begin
                    n_idx     = idx_dec;
                    ram_raddr = isq_pkg::slot_of(r_head, idx_dec);
                end
            end
            isq_pkg::S_PUT: begin
                ram_we      = 1'b1;
                ram_waddr   = isq_pkg::slot_of(r_head, r_pos);
                ram_wdata   = r_val;
                n_held      = r_held + isq_pkg::CNT_BITS'(1);
                n_strobe    = 1'b1;
                n_rsp.count = n_held;
            end
            isq_pkg::S_SCAN: begin
                // First entry seeds the unit; the rest are folded in.
                mm_ctrl.load   = (r_idx == '0);
                mm_ctrl.update = (r_idx != '0);
                if (idx_inc < r_held) begin
                    n_idx     = idx_inc;
                    ram_raddr = isq_pkg::slot_of(r_head, idx_inc);
                end
            end
            isq_pkg::S_MMOUT: begin
                n_strobe         = 1'b1;
                n_rsp.read_value = mm_max;
                n_rsp.min_value  = mm_min;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= isq_pkg::S_IDLE;
            r_head   <= '0;
            r_held   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_held   <= n_held;
            r_strobe <= n_strobe;
        end
    end

    // Payload: hold request fields and the response word.
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_val <= n_val;
        r_rsp <= n_rsp;
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    `ISQ_ASSERT_IMP(a_held_bound, i_clk, i_rst_n, 1'b1, r_held <= isq_pkg::CNT_BITS'(isq_pkg::DEPTH))
    `ISQ_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, r_strobe, r_state == isq_pkg::S_IDLE)
    `ISQ_ASSERT_IMP(a_shift_range, i_clk, i_rst_n, r_state == isq_pkg::S_SHIFT, r_idx >= r_pos)
    `ISQ_ASSERT_IMP(a_scan_range, i_clk, i_rst_n, r_state == isq_pkg::S_SCAN, r_idx < r_held)
    `ISQ_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept, r_strobe || busy)

endmodule
